/* design/sphg_pkg.sv */
package sphg_pkg;

  // Phase and sample formats.
  localparam int PHASE_FRAC_BITS = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = PHASE_FRAC_BITS + 9;
  // Angles fed to a sine lane are up to twice the phase, so one bit wider.
  localparam int ANGLE_BITS      = PHASE_BITS + 1;
  // A folded angle never exceeds a quarter turn (90 < 2^7 degrees).
  localparam int FOLD_BITS       = PHASE_FRAC_BITS + 7;

  localparam logic [ANGLE_BITS-1:0] FULL_TURN    = ANGLE_BITS'(64'd360 << PHASE_FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(64'd180 << PHASE_FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(64'd90 << PHASE_FRAC_BITS);
  localparam logic [PHASE_BITS-1:0] STEP_FLOOR   =
    PHASE_BITS'(((64'd1 << PHASE_FRAC_BITS) + 64'd10) / 64'd20);

  // Q30 arithmetic.
  localparam int Q_BITS  = 30;
  localparam int X_BITS  = 31;  // angle in radians, at most pi/2
  localparam int X2_BITS = 32;  // squared angle
  localparam int T_BITS  = 31;  // series accumulator, at most one
  localparam int N_BITS  = 32;  // series product before the divide
  localparam logic [T_BITS-1:0] Q30_ONE = T_BITS'(64'd1 << Q_BITS);

  // Degrees to radians: a half turn is 45 * 2^(PHASE_FRAC_BITS + 2) units,
  // and pi is split as 45 * PI_HI + PI_LO so only a small remainder is
  // divided by 45.
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned RAD_DIV = 64'd45;
  localparam int RAD_SHIFT   = PHASE_FRAC_BITS + 2;
  localparam int PI_HI_BITS  = 27;
  localparam int PI_LO_BITS  = 6;
  localparam logic [PI_HI_BITS-1:0] PI_HI = PI_HI_BITS'(PI_Q30 / RAD_DIV);
  localparam logic [PI_LO_BITS-1:0] PI_LO = PI_LO_BITS'(PI_Q30 % RAD_DIV);
  localparam int HI_BITS     = FOLD_BITS + PI_HI_BITS;
  localparam int LO_BITS     = FOLD_BITS + PI_LO_BITS;
  localparam int DIV45_SHIFT = LO_BITS + 6;
  localparam logic [LO_BITS:0] DIV45_MAGIC =
    (LO_BITS + 1)'((64'd1 << DIV45_SHIFT) / RAD_DIV + 64'd1);

  // Series steps, highest term first. Each divisor 2k(2k+1) is taken as a
  // halving followed by an exact reciprocal multiply by k(2k+1).
  localparam int SER_STEPS = 7;
  localparam logic [31:0] SER_MAGIC [SER_STEPS] = '{
    32'((64'd1 << 38) / 64'd105 + 64'd1),
    32'((64'd1 << 38) / 64'd78 + 64'd1),
    32'((64'd1 << 37) / 64'd55 + 64'd1),
    32'((64'd1 << 37) / 64'd36 + 64'd1),
    32'((64'd1 << 36) / 64'd21 + 64'd1),
    32'((64'd1 << 35) / 64'd10 + 64'd1),
    32'((64'd1 << 33) / 64'd3 + 64'd1)
  };
  localparam int SER_SHIFT [SER_STEPS] = '{38, 38, 37, 37, 36, 35, 33};

  // Output scaling.
  localparam int NORM_BITS = 30;
  localparam logic [NORM_BITS-1:0] NORM_Q30 = NORM_BITS'(64'd826566842);
  localparam logic [SAMPLE_BITS-2:0] FULL_SCALE = '1;

  typedef struct packed {
    logic              neg;
    logic [X_BITS-1:0] mag;
  } sin_t;

endpackage

/* design/sphg_phase.sv */
module sphg_phase (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [sphg_pkg::PHASE_BITS-1:0]  step_i,
  output logic [sphg_pkg::PHASE_BITS-1:0]  phase_o
);
  import sphg_pkg::*;

  logic [PHASE_BITS-1:0] phase_q, phase_d, step_f;
  logic [ANGLE_BITS-1:0] sum, wrap1, wrap2;

  // The sum can reach almost two and a half turns, so it may wrap twice.
  always_comb begin
    step_f  = (step_i < STEP_FLOOR) ? STEP_FLOOR : step_i;
    sum     = ANGLE_BITS'(phase_q) + ANGLE_BITS'(step_f);
    wrap1   = (sum >= FULL_TURN) ? sum - FULL_TURN : sum;
    wrap2   = (wrap1 >= FULL_TURN) ? wrap1 - FULL_TURN : wrap1;
    phase_d = PHASE_BITS'(wrap2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

/* design/sphg_sine.sv */
module sphg_sine (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [sphg_pkg::ANGLE_BITS-1:0]  angle_i,
  output sphg_pkg::sin_t                   sine_o
);
  import sphg_pkg::*;

  localparam int NT_BITS = X2_BITS + T_BITS;
  localparam int QP_BITS = N_BITS - 1 + 32;

  // Fold the angle into the first quadrant and start the radian product.
  logic [ANGLE_BITS-1:0] wrap_a, half_a;
  logic [FOLD_BITS-1:0]  fold_a;
  logic                  neg_a;

  always_comb begin
    wrap_a = (angle_i >= FULL_TURN) ? angle_i - FULL_TURN : angle_i;
    neg_a  = (wrap_a >= HALF_TURN);
    half_a = neg_a ? wrap_a - HALF_TURN : wrap_a;
    fold_a = (half_a > QUARTER_TURN) ? FOLD_BITS'(HALF_TURN - half_a)
                                     : FOLD_BITS'(half_a);
  end

  logic [HI_BITS-1:0] hi_q;
  logic [LO_BITS-1:0] lo_q;
  logic               neg_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q    <= HI_BITS'(fold_a) * HI_BITS'(PI_HI);
      lo_q    <= LO_BITS'(fold_a) * LO_BITS'(PI_LO);
      neg_a_q <= neg_a;
    end
  end

  // Finish the truncating division by the half turn.
  logic [2*LO_BITS:0] q45_prod;
  logic [LO_BITS-1:0] q45;
  logic [HI_BITS:0]   xsum;
  logic [X_BITS-1:0]  x_b_q;
  logic               neg_b_q;

  always_comb begin
    q45_prod = (2*LO_BITS+1)'(lo_q) * (2*LO_BITS+1)'(DIV45_MAGIC);
    q45      = LO_BITS'(q45_prod >> DIV45_SHIFT);
    xsum     = (HI_BITS+1)'(hi_q) + (HI_BITS+1)'(q45);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_b_q   <= xsum[RAD_SHIFT +: X_BITS];
      neg_b_q <= neg_a_q;
    end
  end

  // Square of the angle.
  logic [2*X_BITS-1:0] sq_prod;
  logic [X2_BITS-1:0]  x2_c_q;
  logic [X_BITS-1:0]   x_c_q;
  logic                neg_c_q;

  assign sq_prod = (2*X_BITS)'(x_b_q) * (2*X_BITS)'(x_b_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_c_q  <= sq_prod[Q_BITS +: X2_BITS];
      x_c_q   <= x_b_q;
      neg_c_q <= neg_b_q;
    end
  end

  // Horner steps of the series, two stages each.
  logic [T_BITS-1:0]  t_s   [SER_STEPS+1];
  logic [X2_BITS-1:0] x2_s  [SER_STEPS+1];
  logic [X_BITS-1:0]  x_s   [SER_STEPS+1];
  logic               neg_s [SER_STEPS+1];

  assign t_s[0]   = Q30_ONE;
  assign x2_s[0]  = x2_c_q;
  assign x_s[0]   = x_c_q;
  assign neg_s[0] = neg_c_q;

  for (genvar i = 0; i < SER_STEPS; i++) begin : g_step
    logic [NT_BITS-1:0] nt_prod;
    logic [QP_BITS-1:0] q_prod;
    logic [N_BITS-1:0]  n_q;
    logic [X2_BITS-1:0] x2_d_q, x2_e_q;
    logic [X_BITS-1:0]  x_d_q, x_e_q;
    logic               neg_d_q, neg_e_q;
    logic [T_BITS-1:0]  t_e_q;

    assign nt_prod = NT_BITS'(x2_s[i]) * NT_BITS'(t_s[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q     <= nt_prod[Q_BITS +: N_BITS];
        x2_d_q  <= x2_s[i];
        x_d_q   <= x_s[i];
        neg_d_q <= neg_s[i];
      end
    end

    assign q_prod = QP_BITS'(n_q[N_BITS-1:1]) * QP_BITS'(SER_MAGIC[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_e_q   <= Q30_ONE - T_BITS'(q_prod >> SER_SHIFT[i]);
        x2_e_q  <= x2_d_q;
        x_e_q   <= x_d_q;
        neg_e_q <= neg_d_q;
      end
    end

    assign t_s[i+1]   = t_e_q;
    assign x2_s[i+1]  = x2_e_q;
    assign x_s[i+1]   = x_e_q;
    assign neg_s[i+1] = neg_e_q;
  end

  // Final multiply by the angle.
  logic [2*X_BITS-1:0] m_prod;
  sin_t                sine_q;

  assign m_prod = (2*X_BITS)'(x_s[SER_STEPS]) * (2*X_BITS)'(t_s[SER_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q.mag <= m_prod[Q_BITS +: X_BITS];
      sine_q.neg <= neg_s[SER_STEPS];
    end
  end

  assign sine_o = sine_q;

endmodule

/* design/sphg_scale.sv */
module sphg_scale (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  sphg_pkg::sin_t                         sin1_i,
  input  sphg_pkg::sin_t                         sin2_i,
  output logic signed [sphg_pkg::SAMPLE_BITS-1:0] sample_o
);
  import sphg_pkg::*;

  localparam int RAW_BITS = X_BITS + 2;
  localparam int MAG_BITS = X_BITS + 1;
  localparam int VP_BITS  = MAG_BITS + NORM_BITS;
  localparam int V_BITS   = 32;
  localparam int RP_BITS  = V_BITS + SAMPLE_BITS;
  localparam int R_BITS   = RP_BITS - Q_BITS;

  // Sum of the fundamental and half the harmonic, the half truncated
  // toward zero, then the peak normalization.
  logic signed [RAW_BITS-1:0] term1, term2, raw;
  logic [MAG_BITS-1:0]        mag;
  logic [VP_BITS-1:0]         v_prod;
  logic [V_BITS-1:0]          v_q;
  logic                       neg_q;

  always_comb begin
    term1  = sin1_i.neg ? -$signed({2'b00, sin1_i.mag})
                        : $signed({2'b00, sin1_i.mag});
    term2  = sin2_i.neg ? -$signed({3'b000, sin2_i.mag[X_BITS-1:1]})
                        : $signed({3'b000, sin2_i.mag[X_BITS-1:1]});
    raw    = term1 + term2;
    mag    = raw[RAW_BITS-1] ? MAG_BITS'(-raw) : MAG_BITS'(raw);
    v_prod = VP_BITS'(mag) * VP_BITS'(NORM_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_prod[Q_BITS +: V_BITS];
      neg_q <= raw[RAW_BITS-1];
    end
  end

  // Scale to full range, round half up on the magnitude, saturate.
  logic [RP_BITS-1:0]     r_prod;
  logic [R_BITS-1:0]      r;
  logic [SAMPLE_BITS-2:0] r_sat;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;

  always_comb begin
    r_prod   = RP_BITS'(v_q) * RP_BITS'(FULL_SCALE) + (RP_BITS'(1) << (Q_BITS - 1));
    r        = R_BITS'(r_prod >> Q_BITS);
    r_sat    = (r > R_BITS'(FULL_SCALE)) ? FULL_SCALE : r[SAMPLE_BITS-2:0];
    sample_d = neg_q ? -$signed({1'b0, r_sat}) : $signed({1'b0, r_sat});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

/* design/sine_plus_harmonic_generator_unit.sv */
// Channel  Direction  Handshake                 Payload
// -------  ---------  ------------------------  ------------------------------
// in       input      in_valid_i / in_ready_o   phase_step_i, 25-bit unsigned
// out      output     out_valid_o / out_ready_i sample_o, 16-bit signed
//
// One item enters per cycle while the output is not stalled. Each accepted
// item passes the phase register, the sine lanes (fold, radian scaling,
// squaring, two stages per series term and the final multiply) and two
// output scaling stages.
// Reset clears the phase to zero degrees and empties the pipeline.
// A result held on the output stalls the whole pipeline until it is taken.

module sine_plus_harmonic_generator_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [sphg_pkg::PHASE_BITS-1:0]         phase_step_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [sphg_pkg::SAMPLE_BITS-1:0] sample_o
);
  import sphg_pkg::*;

  // Phase register, the sine lane stages, and the two scaling stages.
  localparam int SINE_STAGES = 4 + 2 * SER_STEPS;
  localparam int STAGES      = 1 + SINE_STAGES + 2;

  logic              en, accept;
  logic [STAGES-1:0] valid_q, valid_d;
  logic [PHASE_BITS-1:0] phase;
  sin_t              sin1, sin2;

  // The pipeline moves whenever the output register is empty or is being
  // drained this cycle. The valid bits and all stages after the phase register
  // share this enable, so that items stay in lock step with their valid bits.
  assign en          = !valid_q[STAGES-1] || out_ready_i;
  assign accept      = in_valid_i && en;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[STAGES-1];

  assign valid_d = {valid_q[STAGES-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // The phase accumulator is the first pipeline stage; it only moves when an
  // item is accepted, so bubbles leave it untouched.
  sphg_phase u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .step_i   (phase_step_i),
    .phase_o  (phase)
  );

  // Fundamental and second harmonic run in two identical lanes. The
  // harmonic lane sees twice the phase and folds it back into one turn.
  sphg_sine u_sine_fund (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ({1'b0, phase}),
    .sine_o  (sin1)
  );

  sphg_sine u_sine_harm (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ({phase, 1'b0}),
    .sine_o  (sin2)
  );

  // Combine, normalize the peak to one, and scale to the sample range.
  // The last register of this unit is the output register.
  sphg_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (en),
    .sin1_i   (sin1),
    .sin2_i   (sin2),
    .sample_o (sample_o)
  );

endmodule

/* design/sphg_checker.sv */
module sphg_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic signed [sphg_pkg::SAMPLE_BITS-1:0] sample_o
);
  import sphg_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A result waiting on the output stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("output item changed while stalled");

  // Saturation keeps the sample symmetric.
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o != SAMPLE_MIN)
    else $error("sample reached the most negative code");

  // Input back-pressure only comes from a stalled output.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

endmodule

bind sine_plus_harmonic_generator_unit sphg_checker u_sphg_checker (.*);
